FILE: hdl/rv_alu_pkg.sv
// ----------------------------------------------------------------------------
// RV32IM ALU package
// Shared types, opcode constants and the request record passed down the chain.
// ----------------------------------------------------------------------------
package rv_alu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned DIV_CELLS = 32;

  localparam logic [1:0] CLS_REG = 2'd0;
  localparam logic [1:0] CLS_IMM = 2'd1;
  localparam logic [1:0] CLS_BR = 2'd2;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT = 7'h20;
  localparam logic [6:0] F7_MEXT = 7'h01;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SLT = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SR = 3'd5;
  localparam logic [2:0] F3_OR = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;

  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_BLT = 3'd4;
  localparam logic [2:0] F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_MUL = 3'd0;
  localparam logic [2:0] F3_MULH = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU = 3'd3;
  localparam logic [2:0] F3_DIV = 3'd4;
  localparam logic [2:0] F3_DIVU = 3'd5;
  localparam logic [2:0] F3_REM = 3'd6;

  // Request state carried from cell to cell.
  typedef struct packed {
    logic        is_div;
    logic        want_rem;
    logic        neg_q;
    logic        neg_r;
    logic        div_zero;
    logic [XLEN-1:0] a_raw;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dvs;
    logic [XLEN-1:0] res;
    logic        taken;
    logic        bad;
  } req_t;

endpackage

FILE: hdl/rv_alu_front.sv
// ----------------------------------------------------------------------------
// RV32IM ALU front end
// Decodes a request, computes the base results and the branch compare, flags
// multiply requests, and prepares the divider operands.
// ----------------------------------------------------------------------------
module rv_alu_front (
  input  logic [1:0]  func_i,
  input  logic [2:0]  funct3_i,
  input  logic [6:0]  funct7_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output rv_alu_pkg::req_t req_o,
  output logic        is_mul_o,
  output logic [2:0]  mul_f3_o
);
  import rv_alu_pkg::*;

  logic [31:0] a, b, base_res, abs_a, abs_b;
  logic [4:0]  sh;
  logic        alt, lt, ltu, bad, mext, use_base, sgn_div;
  logic [32:0] sra_tmp;

  assign a = operand_a_i;
  assign b = operand_b_i;
  assign sh = b[4:0];
  assign lt = $signed(a) < $signed(b);
  assign ltu = a < b;
  assign sra_tmp = $signed({a[31], a}) >>> sh;

  always_comb begin
    bad = 1'b0;
    mext = 1'b0;
    use_base = 1'b0;
    alt = 1'b0;
    case (func_i)
      CLS_REG: begin
        if (funct7_i == F7_BASE) begin
          use_base = 1'b1;
        end else if (funct7_i == F7_ALT && (funct3_i == F3_ADD || funct3_i == F3_SR)) begin
          use_base = 1'b1;
          alt = 1'b1;
        end else if (funct7_i == F7_MEXT) begin
          mext = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      CLS_IMM: begin
        if (funct3_i == F3_SLL) begin
          use_base = (funct7_i == F7_BASE);
          bad = (funct7_i != F7_BASE);
        end else if (funct3_i == F3_SR) begin
          use_base = (funct7_i == F7_BASE) || (funct7_i == F7_ALT);
          bad = !use_base;
          alt = (funct7_i == F7_ALT);
        end else begin
          use_base = 1'b1;
        end
      end
      CLS_BR: begin
        bad = (funct3_i == 3'd2) || (funct3_i == 3'd3);
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    case (funct3_i)
      F3_ADD:  base_res = alt ? a - b : a + b;
      F3_SLL:  base_res = a << sh;
      F3_SLT:  base_res = {31'd0, lt};
      F3_SLTU: base_res = {31'd0, ltu};
      F3_XOR:  base_res = a ^ b;
      F3_SR:   base_res = alt ? sra_tmp[31:0] : a >> sh;
      F3_OR:   base_res = a | b;
      default: base_res = a & b;
    endcase
  end

  assign sgn_div = !funct3_i[0];
  assign abs_a = (sgn_div && a[31]) ? -a : a;
  assign abs_b = (sgn_div && b[31]) ? -b : b;

  always_comb begin
    req_o = '0;
    req_o.bad = bad;
    req_o.a_raw = a;
    req_o.is_div = mext && funct3_i[2];
    req_o.want_rem = funct3_i[1];
    req_o.div_zero = (b == 32'd0);
    req_o.neg_q = sgn_div && (a[31] ^ b[31]);
    req_o.neg_r = sgn_div && a[31];
    req_o.quo = abs_a;
    req_o.dvs = abs_b;
    if (use_base) begin
      req_o.res = base_res;
    end
    if (func_i == CLS_BR && !bad) begin
      case (funct3_i)
        F3_BEQ:  req_o.taken = (a == b);
        F3_BNE:  req_o.taken = (a != b);
        F3_BLT:  req_o.taken = lt;
        F3_BGE:  req_o.taken = !lt;
        F3_BLTU: req_o.taken = ltu;
        F3_BGEU: req_o.taken = !ltu;
        default: req_o.taken = 1'b0;
      endcase
    end
  end

  assign is_mul_o = mext && !funct3_i[2];
  assign mul_f3_o = funct3_i;

endmodule

FILE: hdl/rv_alu_cell.sv
// ----------------------------------------------------------------------------
// RV32IM ALU divider cell
// One restoring division step per cell; the request moves on each cycle that en_i is high.
// ----------------------------------------------------------------------------
module rv_alu_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  rv_alu_pkg::req_t req_i,
  output logic             vld_o,
  output rv_alu_pkg::req_t req_o
);
  import rv_alu_pkg::*;

  req_t        req_d, req_q;
  logic        vld_q;
  logic [32:0] trial, part;

  always_comb begin
    req_d = req_i;
    part = {req_i.rem, req_i.quo[31]};
    trial = part - {1'b0, req_i.dvs};
    if (req_i.is_div) begin
      if (!trial[32]) begin
        req_d.rem = trial[31:0];
        req_d.quo = {req_i.quo[30:0], 1'b1};
      end else begin
        req_d.rem = part[31:0];
        req_d.quo = {req_i.quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q <= req_d;
    end
  end

  assign vld_o = vld_q;
  assign req_o = req_q;

endmodule

FILE: hdl/rv32im_alu_with_branch_compare_unit.sv
// ----------------------------------------------------------------------------
// RV32IM ALU with branch compare
// Register, immediate and branch-compare execution with the M extension.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid / stall   | func, funct3, funct7, operands
// out     | output    | out_valid / stall  | result, branch_taken, illegal
//
// One request enters per cycle while the output is not stalled. Each request
// passes an input stage, the chain of 32 divider cells and a final fix-up
// stage; the multiplier runs alongside, its product carried down a parallel pipe.
// A stall on a valid output freezes the whole chain and stalls the input.
// Reset empties the chain; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rv32im_alu_with_branch_compare_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [2:0]  funct3_i,
  input  logic [6:0]  funct7_i,
  input  logic [DATA_WIDTH-1:0] operand_a_i,
  input  logic [DATA_WIDTH-1:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [DATA_WIDTH-1:0] result_o,
  output logic        branch_taken_o,
  output logic        illegal_o
);
  import rv_alu_pkg::*;

  req_t        front_req, in_req_q;
  req_t        chain_req [DIV_CELLS+1];
  logic        chain_vld [DIV_CELLS+1];
  logic        is_mul, mul_q, in_vld_q, en;
  logic [2:0]  mul_f3, mf3_q;
  logic [32:0] ma_q, mb_q;
  logic [65:0] prod;
  logic [DIV_CELLS-1:0] pipe_mul;
  logic [31:0] mres_pipe [DIV_CELLS];
  logic [31:0] mres_d, quo_f, rem_f, fin_d, res_q;
  logic        out_vld_q, taken_q, bad_q;

  assign en = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  rv_alu_front u_front (
    .func_i, .funct3_i, .funct7_i,
    .operand_a_i(operand_a_i[31:0]), .operand_b_i(operand_b_i[31:0]),
    .req_o(front_req), .is_mul_o(is_mul), .mul_f3_o(mul_f3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_valid_i;
      out_vld_q <= chain_vld[DIV_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_req_q <= front_req;
      mul_q <= is_mul;
      mf3_q <= mul_f3;
      ma_q <= {(mul_f3 != F3_MULHU) && operand_a_i[31], operand_a_i[31:0]};
      mb_q <= {(mul_f3 == F3_MUL || mul_f3 == F3_MULH) && operand_b_i[31],
               operand_b_i[31:0]};
    end
  end

  assign prod = 66'($signed(ma_q) * $signed(mb_q));

  always_comb begin
    mres_d = (mf3_q == F3_MUL) ? prod[31:0] : prod[63:32];
  end

  assign chain_req[0] = in_req_q;
  assign chain_vld[0] = in_vld_q;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    rv_alu_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(chain_vld[i]), .req_i(chain_req[i]),
      .vld_o(chain_vld[i+1]), .req_o(chain_req[i+1])
    );
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en) begin
          pipe_mul[i] <= mul_q;
          mres_pipe[i] <= mres_d;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (en) begin
          pipe_mul[i] <= pipe_mul[i-1];
          mres_pipe[i] <= mres_pipe[i-1];
        end
      end
    end
  end

  always_comb begin
    req_t r;
    r = chain_req[DIV_CELLS];
    quo_f = r.neg_q ? -r.quo : r.quo;
    rem_f = r.neg_r ? -r.rem : r.rem;
    if (pipe_mul[DIV_CELLS-1]) begin
      fin_d = mres_pipe[DIV_CELLS-1];
    end else if (r.is_div) begin
      if (r.div_zero) begin
        fin_d = r.want_rem ? r.a_raw : '1;
      end else begin
        fin_d = r.want_rem ? rem_f : quo_f;
      end
    end else begin
      fin_d = r.res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= fin_d;
      taken_q <= chain_req[DIV_CELLS].taken;
      bad_q <= chain_req[DIV_CELLS].bad;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o = DATA_WIDTH'(res_q);
  assign branch_taken_o = taken_q;
  assign illegal_o = bad_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(res_q))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_vld_q && out_stall_i))
    else $error("input stall mismatch");
  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && bad_q |-> res_q == '0 && !taken_q)
    else $error("illegal result not cleared");

endmodule

FILE: bench/rv32im_alu_with_branch_compare_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32IM ALU with branch compare testbench
// Drives directed and random register, immediate and branch requests through
// the valid/stall channel with random idle bursts on both sides, predicts each
// result in the bench and compares every field of every result in order.
// ----------------------------------------------------------------------------
module rv32im_alu_with_branch_compare_unit_test;
  import rv_alu_pkg::*;

  typedef struct packed {
    logic [1:0]  cls;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        taken;
    logic        bad;
  } alu_rsp_t;

  localparam int TIMEOUT_CYCLES = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [2:0]  funct3_i = '0;
  logic [6:0]  funct7_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_o;
  logic        branch_taken_o;
  logic        illegal_o;

  alu_req_t pending_reqs[$];
  alu_rsp_t expected_rsps[$];
  int       error_count = 0;
  int       cycle_count = 0;
  bit       stim_done = 1'b0;
  bit       calm = 1'b0;
  bit       in_acc = 1'b0;
  int       drv_gap = 0;
  int       mon_gap = 0;

  always #5 clk_i = ~clk_i;

  rv32im_alu_with_branch_compare_unit u_top (.*);

  function automatic logic [31:0] base_calc(logic [2:0] f3, bit alt, logic [31:0] a,
                                            logic [31:0] b);
    case (f3)
      F3_ADD: return alt ? a - b : a + b;
      F3_SLL: return a << b[4:0];
      F3_SLT: return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR: return a ^ b;
      F3_SR: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR: return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] mext_calc(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] p;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    case (f3)
      F3_MUL: p = sa * sb;
      F3_MULH: p = sa * sb;
      F3_MULHSU: p = sa * $signed({32'd0, b});
      F3_MULHU: p = {32'd0, a} * {32'd0, b};
      F3_DIV: return b == 0 ? '1 : (a == 32'h8000_0000 && b == '1) ? a :
                     32'($signed(a) / $signed(b));
      F3_DIVU: return b == 0 ? '1 : a / b;
      F3_REM: return b == 0 ? a : (a == 32'h8000_0000 && b == '1) ? '0 :
                     32'($signed(a) % $signed(b));
      default: return b == 0 ? a : a % b;
    endcase
    return f3 == F3_MUL ? p[31:0] : p[63:32];
  endfunction

  function automatic alu_rsp_t alu_predict(alu_req_t r);
    alu_rsp_t o;
    o = '0;
    case (r.cls)
      CLS_REG: begin
        if (r.f7 == F7_BASE) o.res = base_calc(r.f3, 1'b0, r.a, r.b);
        else if (r.f7 == F7_ALT && (r.f3 == F3_ADD || r.f3 == F3_SR))
          o.res = base_calc(r.f3, 1'b1, r.a, r.b);
        else if (r.f7 == F7_MEXT) o.res = mext_calc(r.f3, r.a, r.b);
        else o.bad = 1'b1;
      end
      CLS_IMM: begin
        if (r.f3 == F3_SLL) begin
          if (r.f7 == F7_BASE) o.res = base_calc(r.f3, 1'b0, r.a, r.b);
          else o.bad = 1'b1;
        end else if (r.f3 == F3_SR) begin
          if (r.f7 == F7_BASE || r.f7 == F7_ALT)
            o.res = base_calc(r.f3, r.f7 == F7_ALT, r.a, r.b);
          else o.bad = 1'b1;
        end else begin
          o.res = base_calc(r.f3, 1'b0, r.a, r.b);
        end
      end
      CLS_BR: begin
        case (r.f3)
          F3_BEQ: o.taken = r.a == r.b;
          F3_BNE: o.taken = r.a != r.b;
          F3_BLT: o.taken = $signed(r.a) < $signed(r.b);
          F3_BGE: o.taken = !($signed(r.a) < $signed(r.b));
          F3_BLTU: o.taken = r.a < r.b;
          F3_BGEU: o.taken = !(r.a < r.b);
          default: o.bad = 1'b1;
        endcase
      end
      default: o.bad = 1'b1;
    endcase
    if (o.bad) begin
      o.res = '0;
      o.taken = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      4: return 32'($urandom_range(0, 40));
      5: return -32'($urandom_range(1, 40));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [1:0] cls, logic [2:0] f3, logic [6:0] f7, logic [31:0] a,
                         logic [31:0] b);
    pending_reqs.push_back('{cls, f3, f7, a, b});
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  initial begin
    logic [6:0] f7;
    logic [1:0] cls;
    for (int i = 0; i < 8; i++) begin
      add_req(CLS_REG, 3'(i), F7_MEXT, 32'h8000_0000, '1);
      add_req(CLS_REG, 3'(i), F7_MEXT, 32'h7fff_ffff, '0);
    end
    add_req(CLS_REG, F3_ADD, F7_ALT, '0, 32'h8000_0000);
    add_req(CLS_REG, F3_SR, F7_ALT, 32'h8000_0000, 32'h0000_003f);
    add_req(CLS_IMM, F3_SR, F7_ALT, 32'hf000_0000, 32'd4);
    add_req(CLS_IMM, F3_SLL, F7_ALT, 32'd1, 32'd1);
    add_req(CLS_REG, F3_XOR, 7'h7f, '1, '1);
    add_req(CLS_BR, F3_SLT, F7_BASE, '1, '1);
    add_req(CLS_BR, F3_BLT, 7'h7f, 32'h8000_0000, 32'h7fff_ffff);
    add_req(2'd3, F3_ADD, F7_BASE, '1, '1);
    for (int i = 0; i < 700; i++) begin
      cls = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0, 1, 2: f7 = F7_BASE;
        3, 4: f7 = F7_ALT;
        5, 6, 7: f7 = F7_MEXT;
        default: f7 = 7'($urandom);
      endcase
      add_req(cls, 3'($urandom), f7, pick_word(), pick_word());
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      calm <= pending_reqs.size() < 60;
      if (!in_valid_i || in_acc) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          alu_req_t r;
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          func_i <= r.cls;
          funct3_i <= r.f3;
          funct7_i <= r.f7;
          operand_a_i <= r.a;
          operand_b_i <= r.b;
          if (!calm && $urandom_range(0, 15) == 0) drv_gap <= $urandom_range(1, 19);
        end else begin
          in_valid_i <= 1'b0;
          stim_done <= 1'b1;
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        mon_gap <= $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_acc <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        expected_rsps.push_back(alu_predict('{func_i, funct3_i, funct7_i, operand_a_i,
                                              operand_b_i}));
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", result_o, '0);
        end else begin
          alu_rsp_t e;
          e = expected_rsps.pop_front();
          if (result_o !== e.res) report_mismatch("result", result_o, e.res);
          if (branch_taken_o !== e.taken)
            report_mismatch("branch_taken", 32'(branch_taken_o), 32'(e.taken));
          if (illegal_o !== e.bad) report_mismatch("illegal", 32'(illegal_o), 32'(e.bad));
        end
      end
    end
  end

  initial begin
    while (!(stim_done && expected_rsps.size() == 0) && cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("RESULT: ERROR");
    end else begin
      repeat (60) @(posedge clk_i);
      if (error_count == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
    end
    $finish;
  end

endmodule
